FILE: src/rckpc_pkg.sv
package rckpc_pkg;

  // Coordinate width after clipping: holds 0..4096 inclusive
  localparam int COORD_W = 13;
  localparam int RGB_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_RED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_GREEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BLUE   = 3'd6;

  typedef struct packed {
    logic [8:0]       map_width;
    logic [8:0]       map_height;
    logic [15:0]      origin_x;
    logic [15:0]      origin_y;
    logic [RGB_W-1:0] key;
  } cfg_t;

  // One queued command. A write uses x0/y0 as the pixel position and rgb;
  // a query uses the clipped window and the empty flag.
  typedef struct packed {
    logic               is_query;
    logic               empty;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [RGB_W-1:0]   rgb;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN
  } back_state_e;

endpackage

FILE: src/rckpc_front.sv
module rckpc_front import rckpc_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [15:0] rect_left_i,
  input  logic [15:0] rect_top_i,
  input  logic [15:0] rect_right_i,
  input  logic [15:0] rect_bottom_i,
  input  cfg_t        cfg_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic                    valid_q, valid_d;
  logic                    query_q;
  logic [7:0]              px_q, py_q;
  logic [RGB_W-1:0]        rgb_q;
  logic signed [17:0]      l_q, t_q, r_q, b_q;
  logic                    accept;
  logic [COORD_W-1:0]      w_eff, h_eff;
  logic signed [17:0]      w_s, h_s;
  logic signed [17:0]      x0_c, y0_c, x1_c, y1_c;
  logic                    miss, in_range, drop;

  assign accept = start_i && !valid_q;
  assign busy_o = valid_q;

  // Move the rectangle into map space on the way in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q <= action_i;
      px_q    <= pixel_x_i;
      py_q    <= pixel_y_i;
      rgb_q   <= {red_i, green_i, blue_i};
      l_q <= {{2{rect_left_i[15]}}, rect_left_i}
           - {{2{cfg_i.origin_x[15]}}, cfg_i.origin_x};
      r_q <= {{2{rect_right_i[15]}}, rect_right_i}
           - {{2{cfg_i.origin_x[15]}}, cfg_i.origin_x};
      t_q <= {{2{rect_top_i[15]}}, rect_top_i}
           - {{2{cfg_i.origin_y[15]}}, cfg_i.origin_y};
      b_q <= {{2{rect_bottom_i[15]}}, rect_bottom_i}
           - {{2{cfg_i.origin_y[15]}}, cfg_i.origin_y};
    end
  end

  always_comb begin
    w_eff = ({4'b0, cfg_i.map_width} > COORD_W'(MAX_WIDTH)) ?
            COORD_W'(MAX_WIDTH) : {4'b0, cfg_i.map_width};
    h_eff = ({4'b0, cfg_i.map_height} > COORD_W'(MAX_HEIGHT)) ?
            COORD_W'(MAX_HEIGHT) : {4'b0, cfg_i.map_height};
    w_s = $signed({5'b0, w_eff});
    h_s = $signed({5'b0, h_eff});

    miss = (l_q > w_s) || (r_q < 18'sd0) || (t_q > h_s) || (b_q < 18'sd0);
    x0_c = (l_q < 18'sd0) ? 18'sd0 : l_q;
    y0_c = (t_q < 18'sd0) ? 18'sd0 : t_q;
    x1_c = (r_q >= w_s) ? w_s : r_q;
    y1_c = (b_q >= h_s) ? h_s : b_q;

    in_range = ({5'b0, px_q} < COORD_W'(MAX_WIDTH))
            && ({5'b0, py_q} < COORD_W'(MAX_HEIGHT));

    cmd_o.is_query = query_q;
    cmd_o.empty    = miss || (x0_c >= x1_c) || (y0_c >= y1_c);
    cmd_o.rgb      = rgb_q;
    if (query_q) begin
      cmd_o.x0 = x0_c[COORD_W-1:0];
      cmd_o.y0 = y0_c[COORD_W-1:0];
      cmd_o.x1 = x1_c[COORD_W-1:0];
      cmd_o.y1 = y1_c[COORD_W-1:0];
    end else begin
      cmd_o.x0 = {5'b0, px_q};
      cmd_o.y0 = {5'b0, py_q};
      cmd_o.x1 = '0;
      cmd_o.y1 = '0;
    end
  end

  // Drop writes that fall outside storage; hold everything else until queued
  assign drop   = valid_q && !query_q && !in_range;
  assign push_o = valid_q && !drop && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (drop || push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

FILE: src/rckpc_fifo.sv
module rckpc_fifo import rckpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t                   slots_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= data_i;
    end
  end

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QUEUE_CNT_W'(push_i) - QUEUE_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
`endif

endmodule

FILE: src/rckpc_back.sv
module rckpc_back import rckpc_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  input  logic [RGB_W-1:0] key_i,
  output logic             done_o,
  output logic             hit_o
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int MEM_DEPTH = MAX_HEIGHT * (2 ** XW);

  logic [RGB_W-1:0]   mem [MEM_DEPTH];
  logic [RGB_W-1:0]   rd_data_q;
  logic               rd_valid_q;
  back_state_e        state_q, state_d;
  logic [COORD_W-1:0] cx_q, cy_q, xs_q, x1_q, y1_q;
  logic               mem_we, rd_en, load, match, last, row_end;
  logic               done_d, hit_d, done_q, hit_q;
  logic [AW-1:0]      waddr, raddr;

  assign match   = rd_valid_q && (rd_data_q == key_i);
  assign row_end = (cx_q + 1'b1) == x1_q;
  assign last    = row_end && ((cy_q + 1'b1) == y1_q);
  assign waddr   = {cmd_i.y0[YW-1:0], cmd_i.x0[XW-1:0]};
  assign raddr   = {cy_q[YW-1:0], cx_q[XW-1:0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i && cmd_i.is_query && !cmd_i.empty) state_d = BK_SCAN;
      end
      BK_SCAN: begin
        if (match) begin
          state_d = BK_IDLE;
        end else if (last) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = 1'b0;
    mem_we = 1'b0;
    load   = 1'b0;
    rd_en  = 1'b0;
    done_d = 1'b0;
    hit_d  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_o  = !empty_i;
        mem_we = !empty_i && !cmd_i.is_query;
        load   = !empty_i && cmd_i.is_query && !cmd_i.empty;
        done_d = !empty_i && cmd_i.is_query && cmd_i.empty;
      end
      BK_SCAN: begin
        // stop issuing reads once a key pixel shows up
        rd_en  = !match;
        done_d = match;
        hit_d  = match;
      end
      BK_DRAIN: begin
        done_d = 1'b1;
        hit_d  = match;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= cmd_i.rgb;
    end
    if (rd_en) begin
      rd_data_q <= mem[raddr];
    end
  end

  // Walk the window row by row
  always_ff @(posedge clk_i) begin
    if (load) begin
      cx_q <= cmd_i.x0;
      cy_q <= cmd_i.y0;
      xs_q <= cmd_i.x0;
      x1_q <= cmd_i.x1;
      y1_q <= cmd_i.y1;
    end else if (rd_en) begin
      if (row_end) begin
        cx_q <= xs_q;
        cy_q <= cy_q + 1'b1;
      end else begin
        cx_q <= cx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      rd_valid_q <= 1'b0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      done_q     <= done_d;
      hit_q      <= hit_d;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

`ifndef ASSERT_OFF
  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(state_q) == BK_SCAN) else $error("read data without scan");
  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SCAN |-> (cx_q < x1_q) && (cy_q < y1_q))
    else $error("scan position left the window");
  a_drain_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DRAIN |-> rd_valid_q) else $error("drain without pending read");
`endif

endmodule

FILE: src/rect_color_key_pixel_collision.sv
// Channel   Direction  Handshake                    Payload
// command   in         start_i & !busy_o            action_i, pixel_*, red/green/blue_i, rect_*_i
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
// result    out        done_o strobe, one cycle     hit_o
//
// A command is translated as it is accepted and clipped in the next cycle, when it
// enters a four-entry queue; busy_o is high that cycle and for as long as the queue is full.
// A pixel write is popped and written to the map in the same cycle. A query scans one
// map pixel per cycle through the single read port and stops at the first key pixel;
// an empty window is answered without a scan, and nothing is popped while a query scans.
// Reset clears control and restores the register defaults, not the map; results never stall.
module rect_color_key_pixel_collision import rckpc_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  action_i,
  input  logic [7:0]            pixel_x_i,
  input  logic [7:0]            pixel_y_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [15:0]           rect_left_i,
  input  logic [15:0]           rect_top_i,
  input  logic [15:0]           rect_right_i,
  input  logic [15:0]           rect_bottom_i,
  output logic                  done_o,
  output logic                  hit_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [8:0]  map_width_q, map_height_q;
  logic [15:0] origin_x_q, origin_y_q;
  logic [7:0]  key_red_q, key_green_q, key_blue_q;
  cfg_t        cfg;
  cmd_t        push_cmd, head_cmd;
  logic        push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= 9'd256;
      map_height_q <= 9'd256;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      key_red_q    <= '0;
      key_green_q  <= '0;
      key_blue_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i[8:0];
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i[8:0];
        CFG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        CFG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        CFG_KEY_RED:    key_red_q    <= cfg_data_i[7:0];
        CFG_KEY_GREEN:  key_green_q  <= cfg_data_i[7:0];
        CFG_KEY_BLUE:   key_blue_q   <= cfg_data_i[7:0];
        default:        key_blue_q   <= key_blue_q;
      endcase
    end
  end

  always_comb begin
    cfg.map_width  = map_width_q;
    cfg.map_height = map_height_q;
    cfg.origin_x   = origin_x_q;
    cfg.origin_y   = origin_y_q;
    cfg.key        = {key_red_q, key_green_q, key_blue_q};
  end

  rckpc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_right_i  (rect_right_i),
    .rect_bottom_i (rect_bottom_i),
    .cfg_i         (cfg),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  rckpc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .empty_o (empty)
  );

  rckpc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .key_i   (cfg.key),
    .done_o  (done_o),
    .hit_o   (hit_o)
  );

endmodule

FILE: dv/tb_rect_color_key_pixel_collision.sv
module tb_rect_color_key_pixel_collision;
  import rckpc_pkg::*;

  localparam int MAP_DIM      = 256;
  localparam int FILL_LIMIT   = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET  = 100;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct {
    action_e     action;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] rl;
    logic [15:0] rt;
    logic [15:0] rr;
    logic [15:0] rb;
  } item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  action_i = 1'b0;
  logic [7:0]            pixel_x_i = '0;
  logic [7:0]            pixel_y_i = '0;
  logic [7:0]            red_i = '0;
  logic [7:0]            green_i = '0;
  logic [7:0]            blue_i = '0;
  logic [15:0]           rect_left_i = '0;
  logic [15:0]           rect_top_i = '0;
  logic [15:0]           rect_right_i = '0;
  logic [15:0]           rect_bottom_i = '0;
  logic                  done_o;
  logic                  hit_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rect_color_key_pixel_collision #(
    .MAX_WIDTH (MAP_DIM),
    .MAX_HEIGHT(MAP_DIM)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .rect_left_i  (rect_left_i),
    .rect_top_i   (rect_top_i),
    .rect_right_i (rect_right_i),
    .rect_bottom_i(rect_bottom_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Register copy, changed only while the block is idle
  int          cfg_w = 256;
  int          cfg_h = 256;
  int          cfg_ox = 0;
  int          cfg_oy = 0;
  logic [23:0] cfg_key = '0;

  // Map as seen by the accepted items, and the map as planned by the stimulus
  bit [23:0] map_img [0:MAP_DIM*MAP_DIM-1];
  bit [23:0] plan_img [0:MAP_DIM*MAP_DIM-1];
  bit        plan_known [0:MAP_DIM*MAP_DIM-1];

  item_t cmd_backlog[$];
  logic  hit_expect[$];

  int burst_left = 1;
  int gap_left = 0;
  int queued_items = 0;
  int sent_items = 0;
  int load_items = 0;
  int answers = 0;
  int hits_seen = 0;
  int mismatch_cnt = 0;
  int cfg_settings = 0;

  function automatic void clip_window(item_t q, output int x0, output int y0,
                                      output int x1, output int y1);
    int w, h, l, t, r, b;
    w = (cfg_w > MAP_DIM) ? MAP_DIM : cfg_w;
    h = (cfg_h > MAP_DIM) ? MAP_DIM : cfg_h;
    l = int'($signed(q.rl)) - cfg_ox;
    r = int'($signed(q.rr)) - cfg_ox;
    t = int'($signed(q.rt)) - cfg_oy;
    b = int'($signed(q.rb)) - cfg_oy;
    x0 = 0;
    y0 = 0;
    x1 = 0;
    y1 = 0;
    // a rectangle that misses the map leaves the window empty
    if (l <= w && r >= 0 && t <= h && b >= 0) begin
      x0 = (l < 0) ? 0 : l;
      y0 = (t < 0) ? 0 : t;
      x1 = (r >= w) ? w : r;
      y1 = (b >= h) ? h : b;
    end
  endfunction

  function automatic logic predict_hit(item_t q);
    int x0, y0, x1, y1, x, y;
    clip_window(q, x0, y0, x1, y1);
    for (y = y0; y < y1; y++)
      for (x = x0; x < x1; x++)
        if (map_img[y * MAP_DIM + x] == cfg_key) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.action = action_e'($urandom_range(0, 1));
    it.px = 8'($urandom);
    it.py = 8'($urandom);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    it.rl = 16'($urandom);
    it.rt = 16'($urandom);
    it.rr = 16'($urandom);
    it.rb = 16'($urandom);
    return it;
  endfunction

  function automatic logic [23:0] pick_colour();
    case ($urandom_range(0, 5))
      0:       return cfg_key;
      1, 2:    return cfg_key ^ (24'h1 << $urandom_range(0, 23));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic void queue_write(int x, int y, logic [23:0] rgb);
    item_t w;
    w = rand_item();
    w.action = ACT_WRITE;
    w.px = 8'(x);
    w.py = 8'(y);
    {w.red, w.green, w.blue} = rgb;
    plan_img[{w.py, w.px}] = rgb;
    plan_known[{w.py, w.px}] = 1'b1;
    cmd_backlog.push_back(w);
    queued_items++;
  endfunction

  // Queue a query, loading beforehand every unwritten pixel that its scan
  // would read. Drop the query if that takes too many loads.
  function automatic bit plan_query(int l, int t, int r, int b);
    item_t q;
    int x0, y0, x1, y1, x, y, missing;
    bit stop;
    q = rand_item();
    q.action = ACT_QUERY;
    q.rl = clamp16(l);
    q.rt = clamp16(t);
    q.rr = clamp16(r);
    q.rb = clamp16(b);
    clip_window(q, x0, y0, x1, y1);
    missing = 0;
    stop = 1'b0;
    for (y = y0; y < y1 && !stop && missing <= FILL_LIMIT; y++)
      for (x = x0; x < x1 && !stop && missing <= FILL_LIMIT; x++)
        if (!plan_known[y * MAP_DIM + x]) missing++;
        else if (plan_img[y * MAP_DIM + x] == cfg_key) stop = 1'b1;
    if (missing > FILL_LIMIT) return 1'b0;
    stop = 1'b0;
    for (y = y0; y < y1 && !stop; y++)
      for (x = x0; x < x1 && !stop; x++) begin
        if (!plan_known[y * MAP_DIM + x]) queue_write(x, y, pick_colour());
        if (plan_img[y * MAP_DIM + x] == cfg_key) stop = 1'b1;
      end
    cmd_backlog.push_back(q);
    queued_items++;
    return 1'b1;
  endfunction

  function automatic void flag_mismatch(string what, logic want, logic got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("[%0t] %s: expected hit %b, got %b", $time, what, want, got);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAP_WIDTH:  cfg_w = int'(data[8:0]);
      CFG_MAP_HEIGHT: cfg_h = int'(data[8:0]);
      CFG_ORIGIN_X:   cfg_ox = int'($signed(data));
      CFG_ORIGIN_Y:   cfg_oy = int'($signed(data));
      CFG_KEY_RED:    cfg_key[23:16] = data[7:0];
      CFG_KEY_GREEN:  cfg_key[15:8] = data[7:0];
      CFG_KEY_BLUE:   cfg_key[7:0] = data[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(int w, int h, int ox, int oy, logic [23:0] key);
    write_reg(CFG_MAP_WIDTH, 16'(w));
    write_reg(CFG_MAP_HEIGHT, 16'(h));
    write_reg(CFG_ORIGIN_X, 16'(ox));
    write_reg(CFG_ORIGIN_Y, 16'(oy));
    write_reg(CFG_KEY_RED, 16'(key[23:16]));
    write_reg(CFG_KEY_GREEN, 16'(key[15:8]));
    write_reg(CFG_KEY_BLUE, 16'(key[7:0]));
    cfg_settings++;
    @(negedge clk_i);
  endtask

  // Pixel loads give no result: let trailing ones retire after the last answer
  task automatic wait_idle();
    do @(negedge clk_i); while (cmd_backlog.size() != 0 || hit_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_cmds
    item_t nxt;
    bit    take;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        nxt = cmd_backlog.pop_front();
        sent_items++;
        if (nxt.action == ACT_WRITE) begin
          map_img[{nxt.py, nxt.px}] = {nxt.red, nxt.green, nxt.blue};
          load_items++;
        end else begin
          hit_expect.push_back(predict_hit(nxt));
        end
      end
      take = 1'b0;
      if (start_i && busy_o) begin
        take = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() != 0) begin
        take = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = 40;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(0, 6);
          end
        end
      end
      if (take) begin
        nxt = cmd_backlog[0];
        action_i <= nxt.action;
        pixel_x_i <= nxt.px;
        pixel_y_i <= nxt.py;
        red_i <= nxt.red;
        green_i <= nxt.green;
        blue_i <= nxt.blue;
        rect_left_i <= nxt.rl;
        rect_top_i <= nxt.rt;
        rect_right_i <= nxt.rr;
        rect_bottom_i <= nxt.rb;
      end
      start_i <= take;
    end
  end

  always @(posedge clk_i) begin : check_hits
    logic want;
    if (rst_ni && done_o) begin
      answers++;
      if (hit_o === 1'b1) hits_seen++;
      if (hit_expect.size() == 0) begin
        flag_mismatch("result with no query pending", 1'bx, hit_o);
      end else begin
        want = hit_expect.pop_front();
        if (hit_o !== want) flag_mismatch("wrong hit", want, hit_o);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int          w, h, ox, oy, l, t, r, b, sel, phase_goal;
    logic [23:0] key;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: full 256x256 map at the world origin, black key
    queue_write(0, 0, 24'h000000);
    void'(plan_query(-32768, -32768, 32767, 32767));
    queue_write(255, 255, 24'hffffff);
    void'(plan_query(255, 255, 256, 256));
    void'(plan_query(255, 255, 32767, 32767));
    void'(plan_query(256, 0, 300, 10));
    void'(plan_query(0, 0, 0, 5));
    void'(plan_query(10, 3, 5, 8));
    void'(plan_query(32767, 0, 32767, 10));
    void'(plan_query(-32768, -32768, -1, -1));
    void'(plan_query(0, 257, 10, 300));
    queue_write(0, 0, 24'hffffff);
    void'(plan_query(0, 0, 1, 1));
    wait_idle();

    // zero-width map
    load_config(0, 3, 0, 0, 24'hffffff);
    void'(plan_query(-32768, -32768, 32767, 32767));
    wait_idle();

    // oversized size registers clamp to the storage, origin at the far corner
    load_config(511, 511, -32768, -32768, 24'hffffff);
    void'(plan_query(-32768 + 255, -32768 + 255, 32767, 32767));
    void'(plan_query(-32768, -32768, -32767, -32767));
    wait_idle();

    load_config(1, 1, 32767, 32767, 24'h000000);
    void'(plan_query(32767, 32767, 32767, 32767));
    void'(plan_query(-32768, -32768, 32767, 32767));
    wait_idle();

    // Pixel loads that queries need count toward the item total
    while (queued_items < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       w = 256;
        1:       w = 1;
        default: w = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       h = 256;
        1:       h = 1;
        default: h = $urandom_range(2, 12);
      endcase
      ox = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, 80)) - 40;
      oy = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, 80)) - 40;
      case ($urandom_range(0, 4))
        0:       key = 24'h000000;
        1:       key = 24'hffffff;
        default: key = 24'($urandom);
      endcase
      load_config(w, h, ox, oy, key);

      phase_goal = queued_items + $urandom_range(10, 25);
      while (queued_items < phase_goal) begin
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
          queue_write($urandom_range(0, w - 1), $urandom_range(0, h - 1), pick_colour());
        end else if (sel == 3) begin
          queue_write($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
        end else if (sel == 4) begin
          void'(plan_query(int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768));
        end else begin
          // rectangles around the map, mostly small, some spanning it
          l = cfg_ox + int'($urandom_range(0, w + 6)) - 4;
          t = cfg_oy + int'($urandom_range(0, h + 6)) - 4;
          if ($urandom_range(0, 3) == 0) begin
            r = l + int'($urandom_range(0, w + 8)) - 2;
            b = t + int'($urandom_range(0, h + 8)) - 2;
          end else begin
            r = l + int'($urandom_range(0, 8)) - 2;
            b = t + int'($urandom_range(0, 8)) - 2;
          end
          void'(plan_query(l, t, r, b));
        end
      end
      wait_idle();
    end

    $display("%0d items sent, %0d of them pixel loads; %0d queries answered, %0d hits",
             sent_items, load_items, answers, hits_seen);
    $display("%0d register settings applied, %0d mismatches", cfg_settings, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
